### rtl/disk_seek_scheduler_macros.svh
// assertion macros for the disk seek scheduler checker
`ifndef DISK_SEEK_SCHEDULER_MACROS_SVH
`define DISK_SEEK_SCHEDULER_MACROS_SVH
`define DSS_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("lbl failed");
`define DSS_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("lbl failed");
`endif

### rtl/dss_pkg.sv
// shared types and codes for the disk seek scheduler
`default_nettype none
package dss_pkg;
  localparam int unsigned CylW = 16;
  localparam int unsigned TotW = 21;
  localparam logic [TotW-1:0] TotMax = '1;

  localparam logic [1:0] PolFcfs  = 2'd0;
  localparam logic [1:0] PolScan  = 2'd1;
  localparam logic [1:0] PolCscan = 2'd2;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgStart  = 1'b1;

  typedef struct packed {
    logic [CylW-1:0] request_cylinder;
    logic            last_request;
  } dss_in_t;

  typedef struct packed {
    logic [CylW-1:0] from_cylinder;
    logic [CylW-1:0] to_cylinder;
    logic [CylW-1:0] move_distance;
    logic [TotW-1:0] total_seek;
    logic            last_move;
  } dss_out_t;

  // datapath operations ordered by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,    // store a request word, closing word also resets head and total
    OpBegin,   // reset head and total
    OpSortRd,  // read store[idx-1] and store[idx]
    OpSwapLo,  // store[idx-1] takes the lower value
    OpSwapHi,  // store[idx] takes the upper value
    OpScanRd,  // read store at index
    OpMove,    // emit a move to the read cylinder
    OpJump     // emit the c-scan jump to zero
  } dss_op_e;

  typedef struct packed {
    dss_op_e     op;
    logic [5:0]  idx;
    logic        last;
  } dss_cmd_t;

  typedef struct packed {
    logic        swap;     // rd pair out of order
    logic        below;    // rd value below the head
  } dss_sts_t;
endpackage
`default_nettype wire

### rtl/dss_datapath.sv
// request store, comparator and move arithmetic
`default_nettype none
module dss_datapath #(
  parameter int unsigned MaxReq = 16,
  parameter int unsigned IdxW   = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       cyl_i,
  input  wire logic [15:0]       start_i,
  input  wire dss_pkg::dss_cmd_t cmd_i,
  output dss_pkg::dss_sts_t      sts_o,
  output logic                   out_valid_o,
  output dss_pkg::dss_out_t      out_o
);
  import dss_pkg::*;

  logic [CylW-1:0] mem_q [MaxReq];
  logic [CylW-1:0] rda_q, rdb_q;
  logic [IdxW-1:0] ia, ib;
  logic [CylW-1:0] head_q, head_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic [CylW-1:0] mv_dist;
  logic [TotW:0]   sum;
  logic            ov_q, ov_d;
  dss_out_t        out_q, out_d;

  assign ia = cmd_i.idx[IdxW-1:0];
  assign ib = ia - IdxW'(1);

  // one write port for load and both swap halves, two registered reads
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad:   mem_q[ia] <= cyl_i;
      OpSwapLo: mem_q[ib] <= rdb_q;
      OpSwapHi: mem_q[ia] <= rda_q;
      default: ;
    endcase
    if (cmd_i.op == OpSortRd) begin
      rda_q <= mem_q[ib];
      rdb_q <= mem_q[ia];
    end else if (cmd_i.op == OpScanRd) begin
      rda_q <= mem_q[ia];
    end
  end

  assign sts_o.swap  = rda_q > rdb_q;
  assign sts_o.below = rda_q < head_q;

  assign mv_dist = (head_q > rda_q) ? head_q - rda_q : rda_q - head_q;
  assign sum     = {1'b0, tot_q} + (TotW+1)'(mv_dist);

  always_comb begin
    head_d = head_q;
    tot_d  = tot_q;
    ov_d   = 1'b0;
    out_d  = out_q;
    unique case (cmd_i.op)
      OpLoad: begin
        if (cmd_i.last) begin
          head_d = start_i;
          tot_d  = '0;
        end
      end
      OpBegin: begin
        head_d = start_i;
        tot_d  = '0;
      end
      OpMove: begin
        tot_d  = sum[TotW] ? TotMax : sum[TotW-1:0];
        head_d = rda_q;
        ov_d   = 1'b1;
        out_d  = '{head_q, rda_q, mv_dist, tot_d, cmd_i.last};
      end
      OpJump: begin
        head_d = '0;
        ov_d   = 1'b1;
        out_d  = '{head_q, '0, '0, tot_q, cmd_i.last};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      tot_q <= '0;
    end else begin
      ov_q  <= ov_d;
      tot_q <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire

### rtl/dss_controller.sv
// sequencer: load, bubble sort, scan and emit
`default_nettype none
module dss_controller #(
  parameter int unsigned MaxReq = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              last_i,
  input  wire logic [1:0]        policy_i,
  input  wire dss_pkg::dss_sts_t sts_i,
  output dss_pkg::dss_cmd_t      cmd_o,
  output logic                   busy_o
);
  import dss_pkg::*;

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SSortRd  = 3'd1;
  localparam logic [2:0] SSortCmp = 3'd2;
  localparam logic [2:0] SSwapHi  = 3'd3;
  localparam logic [2:0] SFind    = 3'd4;
  localparam logic [2:0] SRd      = 3'd5;
  localparam logic [2:0] SMv      = 3'd6;
  localparam logic [2:0] SJump    = 3'd7;

  localparam logic [1:0] PhUp   = 2'd0;
  localparam logic [1:0] PhDown = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;

  logic [2:0] st_q, st_d;
  logic [5:0] cnt_q, cnt_d;   // held requests
  logic [5:0] i_q, i_d;       // scan index
  logic [5:0] p_q, p_d;       // top pair of the sort pass
  logic [5:0] s_q, s_d;       // first index at or above start
  logic [1:0] ph_q, ph_d;     // emission phase
  logic       rd_q, rd_d;     // read issued, data valid next cycle
  logic [1:0] pol_q, pol_d;
  logic       mv_last;
  dss_cmd_t   cmd;

  always_comb begin
    unique case (ph_q)
      PhDown:  mv_last = i_q == 6'd1;
      PhLow:   mv_last = i_q == s_q - 6'd1;
      default: mv_last = (i_q == cnt_q - 6'd1) &&
                         ((pol_q == PolScan) ? (s_q == 6'd0) : (pol_q != PolCscan));
    endcase
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; p_d = p_q; s_d = s_q;
    ph_d = ph_q; rd_d = 1'b0; pol_d = pol_q;
    cmd = '{OpNone, 6'd0, 1'b0};
    unique case (st_q)
      SIdle: begin
        if (start_i) begin
          if (cnt_q < 6'(MaxReq)) begin
            cmd = '{OpLoad, cnt_q, last_i};
            cnt_d = cnt_q + 6'd1;
          end else if (last_i) begin
            // store full: the closing word is dropped, the batch still runs
            cmd = '{OpBegin, 6'd0, 1'b0};
          end
          if (last_i) begin
            pol_d = policy_i; ph_d = PhUp; s_d = 6'd0; i_d = 6'd0;
            if (policy_i == PolScan || policy_i == PolCscan) begin
              st_d = SSortRd; i_d = 6'd1; p_d = cnt_d - 6'd1;
            end else begin
              st_d = SRd;
            end
          end
        end
      end
      SSortRd: begin
        if (p_q == 6'd0) begin
          st_d = SFind; i_d = 6'd0;
        end else if (i_q > p_q) begin
          // pass done, its largest value has settled at the top
          p_d = p_q - 6'd1; i_d = 6'd1;
        end else begin
          cmd = '{OpSortRd, i_q, 1'b0};
          st_d = SSortCmp;
        end
      end
      SSortCmp: begin
        if (sts_i.swap) begin
          cmd = '{OpSwapLo, i_q, 1'b0}; st_d = SSwapHi;
        end else begin
          i_d = i_q + 6'd1; st_d = SSortRd;
        end
      end
      SSwapHi: begin
        cmd = '{OpSwapHi, i_q, 1'b0}; i_d = i_q + 6'd1; st_d = SSortRd;
      end
      SFind: begin
        if (rd_q) begin
          if (!sts_i.below) begin
            s_d = i_q; st_d = SRd;
          end else begin
            i_d = i_q + 6'd1;
          end
        end else if (i_q >= cnt_q) begin
          s_d = cnt_q; st_d = SRd;
        end else begin
          cmd = '{OpScanRd, i_q, 1'b0}; rd_d = 1'b1;
        end
      end
      SRd: begin
        unique case (ph_q)
          PhDown: begin
            if (i_q == 6'd0) begin
              st_d = SIdle; cnt_d = 6'd0;
            end else begin
              cmd = '{OpScanRd, i_q - 6'd1, 1'b0}; st_d = SMv;
            end
          end
          PhLow: begin
            if (i_q >= s_q) begin
              st_d = SIdle; cnt_d = 6'd0;
            end else begin
              cmd = '{OpScanRd, i_q, 1'b0}; st_d = SMv;
            end
          end
          default: begin
            if (i_q < cnt_q) begin
              cmd = '{OpScanRd, i_q, 1'b0}; st_d = SMv;
            end else if (pol_q == PolScan) begin
              ph_d = PhDown; i_d = s_q;
            end else if (pol_q == PolCscan) begin
              st_d = SJump;
            end else begin
              st_d = SIdle; cnt_d = 6'd0;
            end
          end
        endcase
      end
      SMv: begin
        cmd = '{OpMove, 6'd0, mv_last};
        i_d = (ph_q == PhDown) ? i_q - 6'd1 : i_q + 6'd1;
        st_d = SRd;
        if (mv_last) begin
          st_d = SIdle; cnt_d = 6'd0;
        end
      end
      SJump: begin
        cmd = '{OpJump, 6'd0, s_q == 6'd0};
        ph_d = PhLow; i_d = 6'd0; st_d = SRd;
        if (s_q == 6'd0) begin
          st_d = SIdle; cnt_d = 6'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; i_q <= '0; p_q <= '0; s_q <= '0;
      ph_q <= PhUp; rd_q <= 1'b0; pol_q <= PolFcfs;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; p_q <= p_d; s_q <= s_d;
      ph_q <= ph_d; rd_q <= rd_d; pol_q <= pol_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = st_q != SIdle;
endmodule
`default_nettype wire

### rtl/disk_seek_scheduler.sv
// top level of the disk seek scheduler
// channel | ports                           | handshake
// request | start_i, req_i                  | start_i && !busy_o
// move    | move_valid_o, move_o            | one-cycle strobe, no stall
// config  | cfg_we_i, cfg_idx_i, cfg_data_i | write at edge with cfg_we_i
// a request word loads while idle; the closing word starts the schedule
// scan and c-scan bubble sort first: n*(n-1)/2 pairs, each swapped if out of order
// then a search from the bottom finds the first request at or above the head
// a move reads then emits, the c-scan jump emits; busy_o drops as the final move shows
// reset clears count, sequencer, config, total and valid; store, head and move data are kept
`default_nettype none
module disk_seek_scheduler #(
  parameter int unsigned MAX_REQUESTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire dss_pkg::dss_in_t req_i,
  output logic                  busy_o,
  output logic                  move_valid_o,
  output dss_pkg::dss_out_t     move_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [15:0]      cfg_data_i
);
  import dss_pkg::*;
  localparam int unsigned IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [1:0]  pol_q;
  logic [15:0] start_q;
  dss_cmd_t    cmd;
  dss_sts_t    sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= PolFcfs; start_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgPolicy) pol_q <= cfg_data_i[1:0];
      else start_q <= cfg_data_i;
    end
  end

  dss_controller #(.MaxReq(MAX_REQUESTS)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start_i && !busy_o), .last_i(req_i.last_request),
    .policy_i(pol_q), .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  dss_datapath #(.MaxReq(MAX_REQUESTS), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cyl_i(req_i.request_cylinder), .start_i(start_q),
    .cmd_i(cmd), .sts_o(sts), .out_valid_o(move_valid_o), .out_o(move_o)
  );
endmodule
`default_nettype wire

### rtl/dss_checker.sv
// port checker for the disk seek scheduler
`default_nettype none
`include "disk_seek_scheduler_macros.svh"
module dss_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              move_valid_o,
  input wire dss_pkg::dss_out_t move_o
);
  `DSS_ASSERT_IMP(a_move_busy, clk_i, rst_ni, move_valid_o && !move_o.last_move, busy_o)
  `DSS_ASSERT_IMP(a_dist_le, clk_i, rst_ni, move_valid_o, move_o.total_seek >= 21'(move_o.move_distance))
  `DSS_ASSERT_NXT(a_last_idle, clk_i, rst_ni, move_valid_o && move_o.last_move, !move_valid_o)
  `DSS_ASSERT_NXT(a_take_quiet, clk_i, rst_ni, start_i && !busy_o, !move_valid_o)
endmodule
bind disk_seek_scheduler dss_checker u_chk (.*);
`default_nettype wire

### bench/disk_seek_scheduler_tb.sv
// testbench for the disk seek scheduler: directed and random request batches checked against a predictor
`default_nettype none
module disk_seek_scheduler_tb;
  import dss_pkg::*;

  // policy code with no defined meaning, runs as fcfs
  localparam logic [1:0] PolSpare = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  dss_in_t          req = '0;
  logic             busy;
  logic             move_valid;
  dss_out_t         move;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = CfgPolicy;
  logic [15:0]      cfg_data = '0;

  disk_seek_scheduler uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .move_valid_o(move_valid), .move_o(move), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] held_cyl [16];
  int          held_num = 0;
  logic [1:0]  pol_mode = PolFcfs;
  logic [15:0] head_start = '0;
  logic [20:0] seek_sum;
  dss_out_t    moves_due[$];
  dss_in_t     pending_words[$];
  int          idle_pct = 0;
  int          errors = 0;

  function automatic logic [15:0] cyl_dist(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic add_move(logic [15:0] from, logic [15:0] to, logic [15:0] mv_dist);
    dss_out_t m;
    logic [21:0] t;
    t = {1'b0, seek_sum} + 22'(mv_dist);
    if (t > {1'b0, TotMax}) t = {1'b0, TotMax};
    seek_sum = t[20:0];
    m.from_cylinder = from;
    m.to_cylinder = to;
    m.move_distance = mv_dist;
    m.total_seek = seek_sum;
    m.last_move = 1'b0;
    moves_due.push_back(m);
  endtask

  task automatic schedule_word(dss_in_t w);
    logic [15:0] lst [16];
    logic [15:0] v, head;
    int n, s, j, before_n;
    dss_out_t m;
    if (held_num < 16) begin
      held_cyl[held_num] = w.request_cylinder;
      held_num++;
    end
    if (!w.last_request) return;
    n = held_num;
    held_num = 0;
    seek_sum = '0;
    head = head_start;
    before_n = moves_due.size();
    for (int i = 0; i < n; i++) lst[i] = held_cyl[i];
    if (pol_mode == PolScan || pol_mode == PolCscan) begin
      for (int i = 1; i < n; i++) begin
        v = lst[i];
        j = i;
        while (j > 0 && lst[j-1] > v) begin
          lst[j] = lst[j-1];
          j--;
        end
        lst[j] = v;
      end
      s = 0;
      while (s < n && lst[s] < head) s++;
      for (int i = s; i < n; i++) begin
        add_move(head, lst[i], cyl_dist(head, lst[i]));
        head = lst[i];
      end
      if (pol_mode == PolScan) begin
        for (int i = s; i > 0; i--) begin
          add_move(head, lst[i-1], cyl_dist(head, lst[i-1]));
          head = lst[i-1];
        end
      end else begin
        add_move(head, '0, '0);
        head = '0;
        for (int i = 0; i < s; i++) begin
          add_move(head, lst[i], cyl_dist(head, lst[i]));
          head = lst[i];
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        add_move(head, lst[i], cyl_dist(head, lst[i]));
        head = lst[i];
      end
    end
    if (moves_due.size() > before_n) begin
      m = moves_due[$];
      m.last_move = 1'b1;
      moves_due[moves_due.size()-1] = m;
    end
  endtask

  // driver: a waiting word is held until busy drops
  always @(posedge clk) begin
    if (start && !busy) begin
      schedule_word(req);
      void'(pending_words.pop_front());
    end
    if (!(start && busy)) begin
      if (pending_words.size() > 0 && ($urandom_range(0, 99) >= idle_pct)) begin
        start <= 1'b1;
        req <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dss_out_t e;
    if (rst_n && move_valid) begin
      if (moves_due.size() == 0) begin
        $display("%0t: unexpected move, expected none, actual %h", $time, move);
        errors++;
      end else begin
        e = moves_due.pop_front();
        if (move.from_cylinder !== e.from_cylinder)
          $display("%0t: from_cylinder expected %h actual %h", $time, e.from_cylinder,
                   move.from_cylinder);
        if (move.to_cylinder !== e.to_cylinder)
          $display("%0t: to_cylinder expected %h actual %h", $time, e.to_cylinder,
                   move.to_cylinder);
        if (move.move_distance !== e.move_distance)
          $display("%0t: move_distance expected %h actual %h", $time, e.move_distance,
                   move.move_distance);
        if (move.total_seek !== e.total_seek)
          $display("%0t: total_seek expected %h actual %h", $time, e.total_seek,
                   move.total_seek);
        if (move.last_move !== e.last_move)
          $display("%0t: last_move expected %b actual %b", $time, e.last_move,
                   move.last_move);
        if (move !== e) errors++;
      end
    end
  end

  task automatic push_word(logic [15:0] c, logic last);
    dss_in_t w;
    w.request_cylinder = c;
    w.last_request = last;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPolicy) pol_mode = val[1:0];
    else head_start = val;
  endtask

  // wait until every word is taken and every move has come out
  task automatic drain();
    while (pending_words.size() > 0 || start || busy || moves_due.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_cyl();
    case ($urandom % 6)
      0: return 16'h0000;
      1: return 16'hffff;
      2: return head_start;
      3: return 16'($urandom_range(0, 63));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_batch();
    int n;
    n = ($urandom % 8 == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) push_word(rand_cyl(), i == n - 1);
  endtask

  initial begin
    int phase_items;
    int queued;
    logic [1:0] pol_pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fcfs from reset values, extremes and equal-to-head case
    push_word(16'hffff, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0000, 1'b1);
    drain();
    for (int k = 0; k < 3; k++) begin
      pol_pick = (k == 0) ? PolScan : ((k == 1) ? PolCscan : PolSpare);
      write_reg(CfgPolicy, 16'(pol_pick));
      write_reg(CfgStart, 16'h8000);
      push_word(16'h9000, 1'b0);
      push_word(16'h8000, 1'b0);
      push_word(16'h1234, 1'b0);
      push_word(16'hffff, 1'b1);
      drain();
    end
    // c-scan with nothing below the head, then a single request
    write_reg(CfgPolicy, 16'(PolCscan));
    write_reg(CfgStart, 16'h0000);
    push_word(16'h5555, 1'b0);
    push_word(16'haaaa, 1'b1);
    push_word(16'h0001, 1'b1);
    drain();
    // overfull store: extra words dropped, closing word still schedules
    write_reg(CfgPolicy, 16'(PolScan));
    write_reg(CfgStart, 16'hffff);
    for (int i = 0; i < 18; i++) push_word(16'($urandom), i == 17);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 4 == 1) ? 86 : (ph % 4 == 3 ? 14 : 0);
      write_reg(CfgPolicy, 16'($urandom_range(0, 3)));
      write_reg(CfgStart, (ph == 2) ? 16'h0000 : (ph == 5 ? 16'hffff : 16'($urandom)));
      phase_items = 0;
      while (phase_items < 50) begin
        queued = pending_words.size();
        random_batch();
        phase_items += pending_words.size() - queued;
        while (pending_words.size() > 0) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #60000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

### disk_seek_scheduler.f
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_datapath.sv
rtl/dss_controller.sv
rtl/disk_seek_scheduler.sv
rtl/dss_checker.sv
bench/disk_seek_scheduler_tb.sv
